// ===== hw/rtl/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

   // sequence space
   localparam int SEQ_COUNT = 16;
   localparam int SEQ_W     = $clog2(SEQ_COUNT);
   localparam int CNT_W     = SEQ_W + 1;

   // fixed field widths
   localparam int WIN_W     = 4;
   localparam int POLL_W    = 8;
   localparam int COUNT_W   = 16;
   localparam int ACK_W     = 8;
   localparam int SEQB_W    = 5;
   localparam int BASE_W    = 4;
   localparam int ALU_W     = COUNT_W;

   // channel widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COUNT_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PACKETS = 2'd2;

   // reset values of the registers
   localparam logic [WIN_W-1:0]   WINDOW_RESET  = 4'd1;
   localparam logic [POLL_W-1:0]  TIMEOUT_RESET = 8'd20;
   localparam logic [COUNT_W-1:0] PACKETS_RESET = 16'd0;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_SEND  = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_POLL  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [WIN_W-1:0]   window_size;
      logic [POLL_W-1:0]  timeout_polls;
      logic [COUNT_W-1:0] packet_count;
   } cfg_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             borrow;
   } alu_rsp_type;

   typedef struct packed {
      logic               finished;
      logic               timed_out;
      logic               ack_accepted;
      logic [BASE_W-1:0]  window_base;
      logic [COUNT_W-1:0] packet_index;
      logic [SEQB_W-1:0]  seq_byte;
      logic               sent;
   } result_type;

   // difference of two sequence numbers, wrapped into the sequence space
   function automatic logic [SEQ_W-1:0] seq_wrap(input alu_rsp_type r);
      logic [ALU_W-1:0] t;
      t = r.diff + (r.borrow ? ALU_W'(SEQ_COUNT) : '0);
      return t[SEQ_W-1:0];
   endfunction

   // next sequence number, wrapping at the end of the space
   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
      return (s == SEQ_W'(SEQ_COUNT - 1)) ? '0 : s + SEQ_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/go_back_n_sender_window.sv =====
`default_nettype none

// Go-back-N sender window control over 16 sequence numbers. Each request item carries a
// command (start, send attempt, ack, empty poll) and an ack byte; each one gives exactly
// one response item with the grant, sequence byte, packet index, window base and status
// flags. Items are handled one at a time by a small sequencer around a single shared
// subtractor; a start, or an ack whose sequence number is outside the space, skips the
// compares, and an accepted ack or a timeout rewind sweeps the slot mask one entry a cycle
// to free its slots. The response sits in an output register, so the next request is
// taken while it waits; a response still blocked there holds the following item in its
// final state until the receiver takes it. Registers: 0 window size, 1 empty polls
// tolerated, 2 packets in the transfer.

module go_back_n_sender_window
   import gbn_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // command[1:0], ack_byte[9:2]
   input  wire  [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // sent[0], seq_byte[5:1], packet_index[21:6], window_base[25:22],
   // ack_accepted[26], timed_out[27], finished[28]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                    csr_we,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                 cfg_ff, cfg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff, rsp_data_in;
   result_type              result;
   logic                    ready;
   logic                    done;
   logic                    out_free;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_WINDOW:  cfg_in.window_size   = csr_wdata[WIN_W-1:0];
            REG_TIMEOUT: cfg_in.timeout_polls = csr_wdata[POLL_W-1:0];
            REG_PACKETS: cfg_in.packet_count  = csr_wdata[COUNT_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ready;

   gbn_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid & ready),
      .cmd      (req_tdata[1:0]),
      .ack_byte (req_tdata[2 +: ACK_W]),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .ready    (ready),
      .done     (done),
      .result   (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size   <= WINDOW_RESET;
         cfg_ff.timeout_polls <= TIMEOUT_RESET;
         cfg_ff.packet_count  <= PACKETS_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_alu.sv =====
`default_nettype none

module gbn_alu
   import gbn_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [ALU_W:0] wide;

   // unsigned subtract, borrow set when a is below b
   assign wide       = {1'b0, req.a} - {1'b0, req.b};
   assign rsp.diff   = wide[ALU_W-1:0];
   assign rsp.borrow = wide[ALU_W];

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_seq.sv =====
`default_nettype none

module gbn_seq
   import gbn_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire  [1:0]         cmd,
   input  wire  [ACK_W-1:0]   ack_byte,
   input  cfg_type            cfg,
   input  wire                out_free,
   output logic               ready,
   output logic               done,
   output result_type         result
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_OUTN  = 6'b000010,
      ST_CMP_A = 6'b000100,
      ST_CMP_B = 6'b001000,
      ST_FREE  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [ACK_W-1:0]      idx_ff, idx_in;
   logic [SEQ_W-1:0]      base_ff, base_in;
   logic [SEQ_W-1:0]      next_ff, next_in;
   logic [SEQ_COUNT-1:0]  mask_ff, mask_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [POLL_W-1:0]     poll_ff, poll_in;
   logic [SEQ_W-1:0]      outn_ff, outn_in;
   logic [SEQ_W-1:0]      dist_ff, dist_in;
   logic                  ok_ff, ok_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SEQ_W-1:0]      ptr_ff, ptr_in;
   logic                  sent_ff, sent_in;
   logic [SEQB_W-1:0]     seqb_ff, seqb_in;
   logic [COUNT_W-1:0]    pidx_ff, pidx_in;
   logic                  acc_ff, acc_in;
   logic                  tmo_ff, tmo_in;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   logic [ALU_W-1:0]      win;
   logic [POLL_W:0]       poll_inc;
   logic                  idx_ok;

   gbn_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // window capped to one below the sequence space
   assign win = (ALU_W'(cfg.window_size) > ALU_W'(SEQ_COUNT - 1)) ?
                ALU_W'(SEQ_COUNT - 1) : ALU_W'(cfg.window_size);
   assign poll_inc = {1'b0, poll_ff} + (POLL_W + 1)'(1);
   assign idx_ok   = {1'b0, idx_ff} < (ACK_W + 1)'(SEQ_COUNT);

   // operand select for the shared subtractor
   always_comb begin
      alu_req.a = '0;
      alu_req.b = '0;
      case (state_ff)
         ST_OUTN: begin
            alu_req.a = ALU_W'(next_ff);
            alu_req.b = ALU_W'(base_ff);
         end
         ST_CMP_A: begin
            case (cmd_ff)
               CMD_SEND: begin
                  alu_req.a = ALU_W'(outn_ff);
                  alu_req.b = win;
               end
               CMD_ACK: begin
                  alu_req.a = ALU_W'(idx_ff);
                  alu_req.b = ALU_W'(base_ff);
               end
               CMD_POLL: begin
                  alu_req.a = ALU_W'(cfg.timeout_polls);
                  alu_req.b = ALU_W'(poll_inc);
               end
               default: begin
                  alu_req.a = '0;
               end
            endcase
         end
         ST_CMP_B: begin
            case (cmd_ff)
               CMD_SEND: begin
                  alu_req.a = total_ff;
                  alu_req.b = cfg.packet_count;
               end
               CMD_ACK: begin
                  alu_req.a = ALU_W'(dist_ff);
                  alu_req.b = ALU_W'(outn_ff);
               end
               CMD_POLL: begin
                  alu_req.a = total_ff;
                  alu_req.b = ALU_W'(outn_ff);
               end
               default: begin
                  alu_req.a = '0;
               end
            endcase
         end
         ST_FIN: begin
            alu_req.a = total_ff;
            alu_req.b = cfg.packet_count;
         end
         default: begin
            alu_req.a = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      next_in  = next_ff;
      mask_in  = mask_ff;
      total_in = total_ff;
      poll_in  = poll_ff;
      outn_in  = outn_ff;
      dist_in  = dist_ff;
      ok_in    = ok_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      sent_in  = sent_ff;
      seqb_in  = seqb_ff;
      pidx_in  = pidx_ff;
      acc_in   = acc_ff;
      tmo_in   = tmo_ff;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(cmd);
               idx_in   = ack_byte + {ACK_W{1'b1}};
               sent_in  = 1'b0;
               seqb_in  = '0;
               pidx_in  = '0;
               acc_in   = 1'b0;
               tmo_in   = 1'b0;
               state_in = ST_OUTN;
            end
         end
         ST_OUTN: begin
            outn_in = seq_wrap(alu_rsp);
            case (cmd_ff)
               CMD_START: begin
                  base_in  = '0;
                  next_in  = '0;
                  total_in = '0;
                  poll_in  = '0;
                  mask_in  = '1;
                  state_in = ST_FIN;
               end
               CMD_SEND: begin
                  state_in = ST_CMP_A;
               end
               CMD_ACK: begin
                  poll_in  = '0;
                  state_in = idx_ok ? ST_CMP_A : ST_FIN;
               end
               CMD_POLL: begin
                  state_in = ST_CMP_A;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_CMP_A: begin
            case (cmd_ff)
               CMD_SEND: begin
                  ok_in    = alu_rsp.borrow;
                  state_in = ST_CMP_B;
               end
               CMD_ACK: begin
                  dist_in  = seq_wrap(alu_rsp);
                  state_in = ST_CMP_B;
               end
               CMD_POLL: begin
                  if (alu_rsp.borrow) begin
                     tmo_in   = 1'b1;
                     poll_in  = '0;
                     state_in = ST_CMP_B;
                  end else begin
                     poll_in  = poll_inc[POLL_W-1:0];
                     state_in = ST_FIN;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_CMP_B: begin
            case (cmd_ff)
               CMD_SEND: begin
                  // grant when window, packets and slot all allow it
                  if (ok_ff && alu_rsp.borrow && mask_ff[next_ff]) begin
                     sent_in          = 1'b1;
                     seqb_in          = SEQB_W'(next_ff) + SEQB_W'(1);
                     pidx_in          = total_ff;
                     mask_in[next_ff] = 1'b0;
                     next_in          = seq_inc(next_ff);
                     total_in         = total_ff + COUNT_W'(1);
                  end
                  state_in = ST_FIN;
               end
               CMD_ACK: begin
                  // cumulative ack inside the outstanding range
                  if (alu_rsp.borrow) begin
                     ptr_in   = base_ff;
                     cnt_in   = CNT_W'(dist_ff) + CNT_W'(1);
                     base_in  = seq_inc(idx_ff[SEQ_W-1:0]);
                     acc_in   = 1'b1;
                     state_in = ST_FREE;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               CMD_POLL: begin
                  // rewind to base, saturating the sent count
                  total_in = alu_rsp.borrow ? '0 : alu_rsp.diff;
                  next_in  = base_ff;
                  ptr_in   = base_ff;
                  cnt_in   = CNT_W'(outn_ff);
                  state_in = ST_FREE;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_FREE: begin
            // free one slot a cycle
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               mask_in[ptr_ff] = 1'b1;
               ptr_in          = seq_inc(ptr_ff);
               cnt_in          = cnt_ff - CNT_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ready = (state_ff == ST_IDLE);

   // result item
   assign result.sent         = sent_ff;
   assign result.seq_byte     = seqb_ff;
   assign result.packet_index = pidx_ff;
   assign result.window_base  = BASE_W'(base_ff);
   assign result.ack_accepted = acc_ff;
   assign result.timed_out    = tmo_ff;
   assign result.finished     = ~alu_rsp.borrow;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         next_ff  <= '0;
         mask_ff  <= '1;
         total_ff <= '0;
         poll_ff  <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         mask_ff  <= mask_in;
         total_ff <= total_in;
         poll_ff  <= poll_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      outn_ff <= outn_in;
      dist_ff <= dist_in;
      ok_ff   <= ok_in;
      cnt_ff  <= cnt_in;
      ptr_ff  <= ptr_in;
      sent_ff <= sent_in;
      seqb_ff <= seqb_in;
      pidx_ff <= pidx_in;
      acc_ff  <= acc_in;
      tmo_ff  <= tmo_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_checker.sv =====
`default_nettype none

module gbn_checker
   import gbn_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RSP_DATA_W-1:0]   rsp_tdata
);

   logic       f_sent;
   logic [4:0] f_seqb;
   logic [15:0] f_pidx;
   logic       f_acc;
   logic       f_tmo;

   assign f_sent = rsp_tdata[0];
   assign f_seqb = rsp_tdata[5:1];
   assign f_pidx = rsp_tdata[21:6];
   assign f_acc  = rsp_tdata[26];
   assign f_tmo  = rsp_tdata[27];

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one item at a time: no request taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no grant means zero sequence byte and index
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !f_sent |-> f_seqb == 5'd0 && f_pidx == 16'd0)
      else $error("fields set without a grant");

   // a grant carries a nonzero sequence byte
   a_grant_seqb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && f_sent |-> f_seqb != 5'd0)
      else $error("grant with zero sequence byte");

   // grant, ack and timeout come from different commands
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({f_sent, f_acc, f_tmo}))
      else $error("more than one status flag set");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

`default_nettype wire
